@@ design/hkrd_pkg.sv @@
// Shared constants and the usage code to ASCII translation for the keyboard report differ.
package hkrd_pkg;

   localparam int REPORT_BYTES = 8;
   localparam int MOD_BITS = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] MOD_SCAN_BASE = 8'hE0;
   localparam logic [7:0] SHIFT_MASK = 8'h22;
   localparam logic [7:0] CODE_CAPS = 8'h39;
   localparam logic [7:0] CODE_NUM = 8'h53;
   localparam logic [7:0] CODE_SCROLL = 8'h47;
   localparam logic [2:0] LOCK_NUM = 3'b001;
   localparam logic [2:0] LOCK_CAPS = 3'b010;
   localparam logic [2:0] LOCK_SCROLL = 3'b100;

   function automatic logic [7:0] plain_punct(logic [7:0] code);
      logic [7:0] c;
      c = 8'h00;
      unique case (code)
         8'h27: c = 8'h30;
         8'h2D: c = 8'h2D;
         8'h2E: c = 8'h3D;
         8'h2F: c = 8'h5B;
         8'h30: c = 8'h5D;
         8'h31: c = 8'h5C;
         8'h33: c = 8'h3B;
         8'h34: c = 8'h27;
         8'h35: c = 8'h60;
         8'h36: c = 8'h2C;
         8'h37: c = 8'h2E;
         8'h38: c = 8'h2F;
         default: begin
            if (code >= 8'h1E && code <= 8'h26) begin
               c = code + 8'h13;
            end
         end
      endcase
      return c;
   endfunction

   function automatic logic [7:0] shift_punct(logic [7:0] code);
      logic [7:0] c;
      c = 8'h00;
      unique case (code)
         8'h1E: c = 8'h21;
         8'h1F: c = 8'h40;
         8'h20: c = 8'h23;
         8'h21: c = 8'h24;
         8'h22: c = 8'h25;
         8'h23: c = 8'h5E;
         8'h24: c = 8'h26;
         8'h25: c = 8'h2A;
         8'h26: c = 8'h28;
         8'h27: c = 8'h29;
         8'h2D: c = 8'h5F;
         8'h2E: c = 8'h2B;
         8'h2F: c = 8'h7B;
         8'h30: c = 8'h7D;
         8'h31: c = 8'h7C;
         8'h33: c = 8'h3A;
         8'h34: c = 8'h22;
         8'h35: c = 8'h7E;
         8'h36: c = 8'h3C;
         8'h37: c = 8'h3E;
         8'h38: c = 8'h3F;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Letters are the only entries that caps lock inverts.
   function automatic logic [6:0] key_ascii(logic [7:0] code, logic shift, logic caps);
      logic [7:0] c;
      c = 8'h00;
      if (code >= 8'h04 && code <= 8'h1D) begin
         c = (shift ? 8'h41 : 8'h61) + code - 8'h04;
         if (caps) begin
            c = c ^ 8'h20;
         end
      end else begin
         unique case (code)
            8'h28: c = 8'h0A;
            8'h29: c = 8'h1B;
            8'h2A: c = 8'h08;
            8'h2B: c = 8'h09;
            8'h2C: c = 8'h20;
            8'h4C: c = 8'h7F;
            8'h54: c = 8'h2F;
            8'h55: c = 8'h2A;
            8'h56: c = 8'h2D;
            8'h57: c = 8'h2B;
            8'h58: c = 8'h0A;
            8'h62: c = 8'h30;
            8'h63: c = 8'h2E;
            default: begin
               if (code >= 8'h59 && code <= 8'h61) begin
                  c = code - 8'h28;
               end else if (shift) begin
                  c = shift_punct(code);
               end else begin
                  c = plain_punct(code);
               end
            end
         endcase
      end
      return c[6:0];
   endfunction

endpackage

@@ design/hkrd_req_if.sv @@
// Report channel carrying one keyboard report per word.
interface hkrd_req_if #(parameter int KEY_SLOTS = 6) ();
   logic                   valid;
   logic                   ready;
   logic [6:0]             report_length;
   logic [7:0]             modifier_bits;
   logic [KEY_SLOTS*8-1:0] key_slots;

   modport source(output valid, report_length, modifier_bits, key_slots, input ready);
   modport sink(input valid, report_length, modifier_bits, key_slots, output ready);
endinterface

@@ design/hkrd_rsp_if.sv @@
// Event channel carrying one key event per word.
interface hkrd_rsp_if ();
   logic       valid;
   logic       ready;
   logic [7:0] scancode;
   logic       pressed;
   logic [7:0] held_modifiers;
   logic [6:0] ascii;
   logic [2:0] lock_leds;
   logic       last;

   modport source(output valid, scancode, pressed, held_modifiers, ascii, lock_leds, last,
                  input ready);
   modport sink(input valid, scancode, pressed, held_modifiers, ascii, lock_leds, last,
                output ready);
endinterface

@@ design/hkrd_front.sv @@
// Front end: takes reports, filters rejected ones and builds the change masks.
module hkrd_front
   import hkrd_pkg::*;
#(
   parameter int KEY_SLOTS = 6,
   parameter int ENTRY_W = 8 + 16 * KEY_SLOTS + MOD_BITS + 2 * KEY_SLOTS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic               csr_wdata,
   hkrd_req_if.sink           req_chan,
   output logic               push_valid,
   output logic [ENTRY_W-1:0] push_data,
   input  logic               push_ready
);
   localparam int NE = MOD_BITS + 2 * KEY_SLOTS;

   logic                        en_ff, en_in;
   logic [KEY_SLOTS-1:0][7:0]   prior_ff, prior_in;
   logic [7:0]                  pmods_ff, pmods_in;
   logic [KEY_SLOTS-1:0][7:0]   cur;
   logic [KEY_SLOTS-1:0]        rel_mask, prs_mask;
   logic [MOD_BITS-1:0]         mod_mask;
   logic [NE-1:0]               ev_mask;
   logic                        accept, good;

   always_comb begin
      logic hit;
      cur = req_chan.key_slots;
      mod_mask = req_chan.modifier_bits ^ pmods_ff;
      for (int j = 0; j < KEY_SLOTS; j++) begin
         hit = 1'b0;
         for (int k = 0; k < KEY_SLOTS; k++) begin
            hit = hit | (cur[k] == prior_ff[j]);
         end
         rel_mask[j] = (prior_ff[j] != 8'h00) && !hit;
         hit = 1'b0;
         for (int k = 0; k < KEY_SLOTS; k++) begin
            hit = hit | (prior_ff[k] == cur[j]);
         end
         prs_mask[j] = (cur[j] != 8'h00) && !hit;
      end
      ev_mask = {prs_mask, rel_mask, mod_mask};
   end

   assign req_chan.ready = push_ready;
   assign accept = req_chan.valid && req_chan.ready;
   assign good = accept && en_ff && (req_chan.report_length >= 7'(REPORT_BYTES));
   assign push_valid = good && (ev_mask != '0);
   assign push_data = {req_chan.modifier_bits, prior_ff, cur, ev_mask};

   always_comb begin
      en_in = csr_we ? csr_wdata : en_ff;
      prior_in = good ? cur : prior_ff;
      pmods_in = good ? req_chan.modifier_bits : pmods_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 1'b1;
         prior_ff <= '0;
         pmods_ff <= 8'h00;
      end else begin
         en_ff <= en_in;
         prior_ff <= prior_in;
         pmods_ff <= pmods_in;
      end
   end
endmodule

@@ design/hkrd_queue.sv @@
// Short queue that holds classified reports between the front and back ends.
module hkrd_queue
   import hkrd_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data,
   input  logic             pop_ready
);
   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] mem [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign push_ready = (cnt_ff != CW'(QUEUE_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_data = mem[rd_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_in = do_push ? PW'(wr_ff + 1'b1) : wr_ff;
      rd_in = do_pop ? PW'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = CW'(cnt_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         cnt_in = CW'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

@@ design/hkrd_back.sv @@
// Back end: walks the change masks of one report and sends one event per cycle while the event channel is not stalled.
module hkrd_back
   import hkrd_pkg::*;
#(
   parameter int KEY_SLOTS = 6,
   parameter int ENTRY_W = 8 + 16 * KEY_SLOTS + MOD_BITS + 2 * KEY_SLOTS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   input  logic [ENTRY_W-1:0] pop_data,
   output logic               pop_ready,
   hkrd_rsp_if.source         rsp_chan
);
   localparam int NE = MOD_BITS + 2 * KEY_SLOTS;

   logic                      busy_ff, busy_in;
   logic [NE-1:0]             mask_ff, mask_in;
   logic [7:0]                mods_ff, mods_in;
   logic [KEY_SLOTS-1:0][7:0] prior_ff, prior_in;
   logic [KEY_SLOTS-1:0][7:0] cur_ff, cur_in;
   logic [2:0]                lock_ff, lock_in;
   logic                      rvalid_ff, rvalid_in;
   logic [7:0]                rcode_ff, rcode_in;
   logic                      rpress_ff, rpress_in;
   logic [7:0]                rmods_ff, rmods_in;
   logic [6:0]                rascii_ff, rascii_in;
   logic [2:0]                rlock_ff, rlock_in;
   logic                      rlast_ff, rlast_in;

   logic [NE-1:0]             onehot, rest;
   logic [7:0]                code;
   logic                      press, adv;
   logic [2:0]                toggle;

   assign pop_ready = !busy_ff;
   assign adv = busy_ff && (!rvalid_ff || rsp_chan.ready);

   always_comb begin
      onehot = mask_ff & (~mask_ff + NE'(1));
      rest = mask_ff & ~onehot;
      code = 8'h00;
      press = 1'b0;
      for (int i = 0; i < MOD_BITS; i++) begin
         if (onehot[i]) begin
            code = code | (MOD_SCAN_BASE | 8'(i));
            press = press | mods_ff[i];
         end
      end
      for (int j = 0; j < KEY_SLOTS; j++) begin
         if (onehot[MOD_BITS + j]) begin
            code = code | prior_ff[j];
         end
         if (onehot[MOD_BITS + KEY_SLOTS + j]) begin
            code = code | cur_ff[j];
            press = 1'b1;
         end
      end
      toggle = 3'b000;
      if (press && code == CODE_CAPS) begin
         toggle = LOCK_CAPS;
      end else if (press && code == CODE_NUM) begin
         toggle = LOCK_NUM;
      end else if (press && code == CODE_SCROLL) begin
         toggle = LOCK_SCROLL;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      mask_in = mask_ff;
      mods_in = mods_ff;
      prior_in = prior_ff;
      cur_in = cur_ff;
      lock_in = lock_ff;
      rvalid_in = rvalid_ff && !rsp_chan.ready;
      rcode_in = rcode_ff;
      rpress_in = rpress_ff;
      rmods_in = rmods_ff;
      rascii_in = rascii_ff;
      rlock_in = rlock_ff;
      rlast_in = rlast_ff;
      if (!busy_ff && pop_valid) begin
         busy_in = 1'b1;
         {mods_in, prior_in, cur_in, mask_in} = pop_data;
      end else if (adv) begin
         busy_in = (rest != '0);
         mask_in = rest;
         lock_in = lock_ff ^ toggle;
         rvalid_in = 1'b1;
         rcode_in = code;
         rpress_in = press;
         rmods_in = mods_ff;
         rascii_in = key_ascii(code, (mods_ff & SHIFT_MASK) != 8'h00, lock_ff[1]);
         rlock_in = lock_ff ^ toggle;
         rlast_in = (rest == '0);
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      mods_ff <= mods_in;
      prior_ff <= prior_in;
      cur_ff <= cur_in;
      rcode_ff <= rcode_in;
      rpress_ff <= rpress_in;
      rmods_ff <= rmods_in;
      rascii_ff <= rascii_in;
      rlock_ff <= rlock_in;
      rlast_ff <= rlast_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         lock_ff <= 3'b000;
         rvalid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         lock_ff <= lock_in;
         rvalid_ff <= rvalid_in;
      end
   end

   assign rsp_chan.valid = rvalid_ff;
   assign rsp_chan.scancode = rcode_ff;
   assign rsp_chan.pressed = rpress_ff;
   assign rsp_chan.held_modifiers = rmods_ff;
   assign rsp_chan.ascii = rascii_ff;
   assign rsp_chan.lock_leds = rlock_ff;
   assign rsp_chan.last = rlast_ff;
endmodule

@@ design/hid_keyboard_report_differ_top.sv @@
// Top level of the boot keyboard report differ.
// Each accepted report word is compared with the last report that was not rejected and turns
// into zero to 8 + 2*KEY_SLOTS event words: modifier changes, then releases, then presses,
// the final one flagged by last. The front end places each report that brings a change in a
// two-entry queue; the back end loads it and then sends one event word per cycle while the
// event channel is not stalled. Reports that are rejected or bring no change produce nothing.
// The report channel stalls only while the queue is full.
module hid_keyboard_report_differ_top
   import hkrd_pkg::*;
#(
   parameter int KEY_SLOTS = 6
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_wdata,
   hkrd_req_if.sink   req_chan,
   hkrd_rsp_if.source rsp_chan
);
   localparam int ENTRY_W = 8 + 16 * KEY_SLOTS + MOD_BITS + 2 * KEY_SLOTS;

   logic               push_valid, push_ready, pop_valid, pop_ready;
   logic [ENTRY_W-1:0] push_data, pop_data;

   hkrd_front #(.KEY_SLOTS(KEY_SLOTS), .ENTRY_W(ENTRY_W)) u_front (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .req_chan(req_chan),
      .push_valid(push_valid),
      .push_data(push_data),
      .push_ready(push_ready)
   );

   hkrd_queue #(.WIDTH(ENTRY_W)) u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_data(push_data),
      .push_ready(push_ready),
      .pop_valid(pop_valid),
      .pop_data(pop_data),
      .pop_ready(pop_ready)
   );

   hkrd_back #(.KEY_SLOTS(KEY_SLOTS), .ENTRY_W(ENTRY_W)) u_back (
      .clock(clock),
      .reset(reset),
      .pop_valid(pop_valid),
      .pop_data(pop_data),
      .pop_ready(pop_ready),
      .rsp_chan(rsp_chan)
   );
endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the boot keyboard report differ with a local event predictor.
module testbench;
   import hkrd_pkg::*;

   localparam int KEY_SLOTS = 6;
   localparam int HALF_PERIOD = 5;
   localparam int RESET_CYCLES = 12;
   localparam int MAX_EVENTS = MOD_BITS + 2 * KEY_SLOTS;
   localparam int SETTLE_CYCLES = 60;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_HALF = 46;
   localparam int MAX_REPORTED = 10;

   // ASCII rows for usage codes 0x1E..0x38 and the keypad block 0x54..0x63.
   localparam logic [8*27-1:0] PLAIN_ROW =
      216'h31_32_33_34_35_36_37_38_39_30_0A_1B_08_09_20_2D_3D_5B_5D_5C_00_3B_27_60_2C_2E_2F;
   localparam logic [8*27-1:0] SHIFTED_ROW =
      216'h21_40_23_24_25_5E_26_2A_28_29_0A_1B_08_09_20_5F_2B_7B_7D_7C_00_3A_22_7E_3C_3E_3F;
   localparam logic [8*16-1:0] KEYPAD_ROW = 128'h2F_2A_2D_2B_0A_31_32_33_34_35_36_37_38_39_30_2E;

   typedef struct packed {
      logic [6:0]                len;
      logic [7:0]                mods;
      logic [KEY_SLOTS-1:0][7:0] keys;
   } report_type;

   typedef struct packed {
      logic [7:0] scancode;
      logic       pressed;
      logic [7:0] held_modifiers;
      logic [6:0] ascii;
      logic [2:0] lock_leds;
      logic       last;
   } key_event_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_wdata;

   hkrd_req_if #(.KEY_SLOTS(KEY_SLOTS)) req_chan ();
   hkrd_rsp_if rsp_chan ();

   hid_keyboard_report_differ_top #(.KEY_SLOTS(KEY_SLOTS)) i_dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   report_type    report_queue[$];
   key_event_type key_events[$];

   logic                      csr_enabled;
   logic [KEY_SLOTS-1:0][7:0] held_keys;
   logic [7:0]                held_mods;
   logic [2:0]                lock_now;

   logic [KEY_SLOTS-1:0][7:0] typing_keys;
   logic [7:0]                typing_mods;

   bit  req_taken;
   bit  rsp_taken;
   int  reports_queued;
   int  reports_taken;
   int  mismatch_count;
   int  idle_cycles;
   int  gap_left;
   int  burst_left;
   int  pattern_age;
   logic [15:0] stall_pattern;

   always #(HALF_PERIOD) clock = ~clock;

   function automatic logic [6:0] char_of(logic [7:0] code, logic shift, logic caps);
      logic [7:0] c;
      c = 8'h00;
      if (code >= 8'h04 && code <= 8'h1D) begin
         c = ((shift ^ caps) ? 8'h41 : 8'h61) + (code - 8'h04);
      end else if (code >= 8'h1E && code <= 8'h38) begin
         c = shift ? SHIFTED_ROW[8 * (8'h38 - code) +: 8] : PLAIN_ROW[8 * (8'h38 - code) +: 8];
      end else if (code >= 8'h54 && code <= 8'h63) begin
         c = KEYPAD_ROW[8 * (8'h63 - code) +: 8];
      end else if (code == 8'h4C) begin
         c = 8'h7F;
      end
      return c[6:0];
   endfunction

   function automatic logic slot_holds(logic [KEY_SLOTS-1:0][7:0] keys, logic [7:0] code);
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (keys[i] == code) begin
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic key_event_type make_event(logic [7:0] code, logic down, logic [7:0] mods);
      key_event_type ev;
      ev.scancode = code;
      ev.pressed = down;
      ev.held_modifiers = mods;
      ev.ascii = char_of(code, (mods & SHIFT_MASK) != 0, (lock_now & LOCK_CAPS) != 0);
      ev.lock_leds = lock_now;
      ev.last = 1'b0;
      return ev;
   endfunction

   task automatic predict_report(input report_type r);
      key_event_type batch [0:MAX_EVENTS-1];
      key_event_type ev;
      int n;
      n = 0;
      if (!csr_enabled || r.len < REPORT_BYTES) begin
         return;
      end
      for (int b = 0; b < MOD_BITS; b++) begin
         if (r.mods[b] != held_mods[b]) begin
            batch[n] = make_event(MOD_SCAN_BASE + 8'(b), r.mods[b], r.mods);
            n++;
         end
      end
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (held_keys[i] != 8'h00 && !slot_holds(r.keys, held_keys[i])) begin
            batch[n] = make_event(held_keys[i], 1'b0, r.mods);
            n++;
         end
      end
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (r.keys[i] != 8'h00 && !slot_holds(held_keys, r.keys[i])) begin
            ev = make_event(r.keys[i], 1'b1, r.mods);
            case (r.keys[i])
               CODE_CAPS: lock_now ^= LOCK_CAPS;
               CODE_NUM: lock_now ^= LOCK_NUM;
               CODE_SCROLL: lock_now ^= LOCK_SCROLL;
               default: ;
            endcase
            ev.lock_leds = lock_now;
            batch[n] = ev;
            n++;
         end
      end
      held_keys = r.keys;
      held_mods = r.mods;
      for (int k = 0; k < n; k++) begin
         ev = batch[k];
         ev.last = (k == n - 1);
         key_events.push_back(ev);
      end
   endtask

   task automatic note_mismatch(input string what, input key_event_type want,
                                input key_event_type seen);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTED) begin
         $display("%s: expected code=%h pressed=%b mods=%h ascii=%h leds=%b last=%b",
                  what, want.scancode, want.pressed, want.held_modifiers, want.ascii,
                  want.lock_leds, want.last);
         $display("   got      code=%h pressed=%b mods=%h ascii=%h leds=%b last=%b",
                  seen.scancode, seen.pressed, seen.held_modifiers, seen.ascii,
                  seen.lock_leds, seen.last);
      end
   endtask

   function automatic report_type report_of(logic [6:0] len, logic [7:0] mods, logic [7:0] k0,
                                            logic [7:0] k1, logic [7:0] k2, logic [7:0] k3,
                                            logic [7:0] k4, logic [7:0] k5);
      report_type r;
      r.len = len;
      r.mods = mods;
      r.keys = {k5, k4, k3, k2, k1, k0};
      return r;
   endfunction

   function automatic logic [7:0] pick_key();
      case ($urandom_range(0, 9))
         0, 1, 2: return 8'($urandom_range(8'h04, 8'h1D));
         3: return 8'($urandom_range(8'h1E, 8'h27));
         4: return 8'($urandom_range(8'h28, 8'h38));
         5: begin
            case ($urandom_range(0, 2))
               0: return CODE_CAPS;
               1: return CODE_NUM;
               default: return CODE_SCROLL;
            endcase
         end
         6: return 8'($urandom_range(8'h53, 8'h63));
         7: return 8'($urandom_range(8'h39, 8'h52));
         8: return 8'($urandom_range(8'h64, 8'hFF));
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   task automatic next_typed_report(output report_type r);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         r.len = 7'($urandom_range(0, 127));
         r.mods = 8'($urandom);
         r.keys = {16'($urandom), 32'($urandom)};
         return;
      end
      if (roll >= 12) begin
         for (int i = 0; i < KEY_SLOTS; i++) begin
            if ($urandom_range(0, 3) == 0) begin
               typing_keys[i] = ($urandom_range(0, 2) == 0) ? 8'h00 : pick_key();
            end
         end
         if ($urandom_range(0, 19) == 0) begin
            typing_keys[$urandom_range(0, KEY_SLOTS - 1)] =
               typing_keys[$urandom_range(0, KEY_SLOTS - 1)];
         end
         if ($urandom_range(0, 2) == 0) begin
            typing_mods ^= 8'h01 << $urandom_range(0, 7);
         end
      end
      r.mods = typing_mods;
      r.keys = typing_keys;
      if ($urandom_range(0, 9) == 0) begin
         r.len = 7'($urandom_range(0, REPORT_BYTES - 1));
      end else if ($urandom_range(0, 9) == 0) begin
         r.len = 7'($urandom_range(65, 127));
      end else begin
         r.len = 7'($urandom_range(REPORT_BYTES, 64));
      end
   endtask

   task automatic queue_report(input report_type r);
      report_queue.push_back(r);
      reports_queued++;
   endtask

   task automatic queue_typed_reports(input int target);
      report_type r;
      int counted;
      counted = 0;
      while (counted < target) begin
         next_typed_report(r);
         queue_report(r);
         if (r.len >= REPORT_BYTES) begin
            counted++;
         end
      end
   endtask

   task automatic drain_and_settle();
      while (reports_taken != reports_queued || key_events.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_enable(input logic value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      csr_enabled = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   always @(negedge clock) begin : drive_reports
      report_type next_report;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (gap_left > 0) begin
            req_chan.valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (report_queue.size() > 0) begin
            next_report = report_queue.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.report_length <= next_report.len;
            req_chan.modifier_bits <= next_report.mods;
            req_chan.key_slots <= next_report.keys;
            if (burst_left > 1) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(1, 30);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : pace_events
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pattern = 16'hFFFF;
               1: stall_pattern = 16'($urandom);
               2: stall_pattern = 16'($urandom | $urandom);
               default: stall_pattern = 16'h0001 << $urandom_range(0, 15);
            endcase
            if (stall_pattern == 16'h0000) begin
               stall_pattern = 16'h0001;
            end
            pattern_age = $urandom_range(16, 96);
         end
         pattern_age--;
         rsp_chan.ready <= stall_pattern[0];
         stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      end
   end

   always @(posedge clock) begin : watch_channels
      key_event_type seen;
      key_event_type want;
      req_taken = !reset && req_chan.valid && req_chan.ready;
      rsp_taken = !reset && rsp_chan.valid && rsp_chan.ready;
      if (rsp_taken) begin
         seen = key_event_type'{scancode: rsp_chan.scancode, pressed: rsp_chan.pressed,
                                held_modifiers: rsp_chan.held_modifiers,
                                ascii: rsp_chan.ascii, lock_leds: rsp_chan.lock_leds,
                                last: rsp_chan.last};
         if (key_events.size() == 0) begin
            note_mismatch("unexpected event", '0, seen);
         end else begin
            want = key_events.pop_front();
            if (seen !== want) begin
               note_mismatch("event mismatch", want, seen);
            end
         end
      end
      if (req_taken) begin
         reports_taken++;
         predict_report(report_type'{len: req_chan.report_length,
                                     mods: req_chan.modifier_bits,
                                     keys: req_chan.key_slots});
      end
      if (req_taken || rsp_taken) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no traffic for %0d cycles, %0d events outstanding",
                  idle_cycles, key_events.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.report_length = '0;
      req_chan.modifier_bits = '0;
      req_chan.key_slots = '0;
      rsp_chan.ready = 1'b0;
      csr_enabled = 1'b1;
      held_keys = '0;
      held_mods = '0;
      lock_now = '0;
      typing_keys = '0;
      typing_mods = '0;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      reports_queued = 0;
      reports_taken = 0;
      mismatch_count = 0;
      idle_cycles = 0;
      gap_left = 0;
      burst_left = 0;
      pattern_age = 0;
      stall_pattern = 16'hFFFF;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_enable(1'b1);

      // Hand-picked reports: modifier sweeps, full event bursts, lock keys and rejections.
      queue_report(report_of(8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      queue_report(report_of(64, 8'hFF, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h1D));
      queue_report(report_of(8, 8'h00, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h27));
      queue_report(report_of(127, 8'h02, 8'h2D, 8'h2E, 8'h32, 8'h38, 8'h34, 8'h35));
      queue_report(report_of(9, 8'h20, 8'h39, 8'h04, 8'h33, 8'h00, 8'h00, 8'h00));
      queue_report(report_of(8, 8'h00, 8'h04, 8'h39, 8'h05, 8'h00, 8'h00, 8'h00));
      queue_report(report_of(8, 8'h00, 8'h00, 8'h00, 8'h05, 8'h00, 8'h00, 8'h00));
      queue_report(report_of(8, 8'h00, 8'h39, 8'h39, 8'h0A, 8'h53, 8'h53, 8'h47));
      queue_report(report_of(8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      queue_report(report_of(7, 8'h11, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
      queue_report(report_of(0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      queue_report(report_of(8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      queue_report(report_of(8, 8'h80, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59));
      queue_report(report_of(8, 8'h40, 8'h62, 8'h63, 8'h4C, 8'h28, 8'h29, 8'h2A));
      queue_report(report_of(8, 8'h04, 8'h2B, 8'h2C, 8'h01, 8'h02, 8'h03, 8'h67));
      queue_report(report_of(8, 8'h08, 8'h68, 8'h80, 8'hE0, 8'hFF, 8'hAA, 8'h55));
      queue_report(report_of(8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      queue_report(report_of(8, 8'h01, 8'h3A, 8'h47, 8'h39, 8'h10, 8'h00, 8'h00));
      queue_report(report_of(8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      drain_and_settle();

      write_enable(1'b0);
      queue_typed_reports(8);
      drain_and_settle();
      write_enable(1'b1);

      queue_typed_reports(RANDOM_HALF);
      drain_and_settle();
      queue_typed_reports(RANDOM_HALF);
      drain_and_settle();

      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/hkrd_pkg.sv
design/hkrd_req_if.sv
design/hkrd_rsp_if.sv
design/hkrd_front.sv
design/hkrd_queue.sv
design/hkrd_back.sv
design/hid_keyboard_report_differ_top.sv
dv/testbench.sv
